[hw/rtl/dsr_pkg.sv]
// Shared types and constants for the disk request scheduler.
package dsr_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int BLOCK_W     = 16;
  localparam int TAG_W       = 8;
  localparam int RANK_W      = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TRAVEL_W    = 32;

  // Opcodes
  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // Scheduling policies (code 3 behaves as circular scan)
  localparam logic [1:0] POL_FCFS  = 2'd0;
  localparam logic [1:0] POL_SSTF  = 2'd1;
  localparam logic [1:0] POL_CSCAN = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_DISPATCHED = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  // Best candidate handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] block;
    logic               is_write;
    logic [TAG_W-1:0]   tag;
    logic [RANK_W-1:0]  rank;
    logic [BLOCK_W-1:0] seek;
    logic               above;
  } cand_t;

  // Settings every cell compares against
  typedef struct packed {
    logic [1:0]         policy;
    logic [BLOCK_W-1:0] head;
  } cell_ctl_t;

  // Enqueue write offered down the chain
  typedef struct packed {
    logic               en;
    logic [BLOCK_W-1:0] block;
    logic               is_write;
    logic [TAG_W-1:0]   tag;
    logic [RANK_W-1:0]  rank;
  } cell_wr_t;

  // Removal of the dispatched entry, broadcast by rank
  typedef struct packed {
    logic              en;
    logic [RANK_W-1:0] rank;
  } cell_rmv_t;

endpackage

[hw/rtl/dsr_cell.sv]
// One table entry plus one stage of the best-candidate compare chain.
module dsr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dsr_pkg::cell_ctl_t ctl,
  input  dsr_pkg::cell_wr_t  wr,
  input  dsr_pkg::cell_rmv_t rmv,
  input  logic               taken_in,
  output logic               taken_out,
  input  dsr_pkg::cand_t     cand_in,
  output dsr_pkg::cand_t     cand_out,
  output logic               valid_o
);
  import dsr_pkg::*;

  logic               valid_r;
  logic [BLOCK_W-1:0] block_r;
  logic               is_write_r;
  logic [TAG_W-1:0]   tag_r;
  logic [RANK_W-1:0]  rank_r;
  cand_t              cand_r;
  cand_t              own;
  logic               own_wins;
  logic               write_here;

  // true if entry a beats entry b under the active policy
  function automatic logic beats(input cand_t a, input cand_t b, input logic [1:0] pol);
    logic res;
    res = 1'b0;
    case (pol)
      POL_FCFS: res = a.rank < b.rank;
      POL_SSTF: begin
        if (a.seek != b.seek) res = a.seek < b.seek;
        else                  res = a.rank > b.rank;
      end
      default: begin
        if (a.above != b.above)      res = a.above;
        else if (a.block != b.block) res = a.block < b.block;
        else                         res = a.rank > b.rank;
      end
    endcase
    return res;
  endfunction

  // Own entry seen as a candidate
  always_comb begin
    own.valid    = valid_r;
    own.block    = block_r;
    own.is_write = is_write_r;
    own.tag      = tag_r;
    own.rank     = rank_r;
    own.above    = block_r >= ctl.head;
    own.seek     = (block_r >= ctl.head) ? block_r - ctl.head : ctl.head - block_r;
  end

  assign own_wins   = valid_r && (!cand_in.valid || beats(own, cand_in, ctl.policy));
  assign write_here = wr.en && !taken_in && !valid_r;
  assign taken_out  = taken_in || !valid_r;
  assign cand_out   = cand_r;
  assign valid_o    = valid_r;

  // Compare stage: pass the better of the incoming and own entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= own_wins ? own : cand_in;
    end
  end

  // Entry valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (write_here) begin
      valid_r <= 1'b1;
    end else if (rmv.en && valid_r && rank_r == rmv.rank) begin
      valid_r <= 1'b0;
    end
  end

  // Entry payload and arrival rank
  always_ff @(posedge clk) begin
    if (write_here) begin
      block_r    <= wr.block;
      is_write_r <= wr.is_write;
      tag_r      <= wr.tag;
      rank_r     <= wr.rank;
    end else if (rmv.en && valid_r && rank_r > rmv.rank) begin
      rank_r <= rank_r - 1'b1;
    end
  end

endmodule

[hw/rtl/disk_request_scheduler_unit.sv]
// Top level of the disk request scheduler: control, head and travel state, cell chain.
//
// Usage:
//   Items enter on in_* with start; a transfer happens when start is high and busy low.
//   opcode 0 stores a request in a free table entry; opcode 1 dispatches one entry
//   chosen by the policy in cfg_wdata (written with cfg_we while idle).
//   Each item gives one result on out_* marked by out_valid for one cycle; the
//   receiver cannot stall, so results must be taken when shown.
// Results and throughput:
//   Enqueue, and dispatch from an empty table: result registered and shown in the
//   cycle after the transfer; busy stays low, so one such item per cycle.
//   Dispatch from a non-empty table: busy high through the scan and finish states,
//   and the result is shown as busy falls. The wait is set by the best
//   candidate walking the chain of TABLE_DEPTH compare cells, one cell per cycle,
//   and then by the finish state that retires the winner.
// Reset:
//   rst_n low clears the valid bits, occupancy, head position, travel sum and
//   selects first come first served. Entry payloads are not cleared.
module disk_request_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [dsr_pkg::BLOCK_W-1:0] in_request_block,
  input  logic                        in_request_is_write,
  input  logic [dsr_pkg::TAG_W-1:0]   in_request_tag,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [dsr_pkg::BLOCK_W-1:0] out_block,
  output logic                        out_is_write,
  output logic [dsr_pkg::TAG_W-1:0]   out_tag,
  output logic [dsr_pkg::BLOCK_W-1:0] out_seek_distance,
  output logic [dsr_pkg::TRAVEL_W-1:0] out_total_travel
);
  import dsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [RANK_W-1:0]    cnt_r, cnt_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [BLOCK_W-1:0]   head_r, head_nxt;
  logic [TRAVEL_W-1:0]  travel_r, travel_nxt;
  logic [1:0]           policy_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [BLOCK_W-1:0]   out_block_r, out_block_nxt;
  logic                 out_is_write_r, out_is_write_nxt;
  logic [TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic [BLOCK_W-1:0]   out_seek_r, out_seek_nxt;
  logic [TRAVEL_W-1:0]  out_travel_r, out_travel_nxt;

  cell_ctl_t            ctl;
  cell_wr_t             wr;
  cell_rmv_t            rmv;
  cand_t                cand_w [TABLE_DEPTH];
  cand_t                best;
  logic [TABLE_DEPTH:0] taken_w;
  logic [TABLE_DEPTH-1:0] valid_w;
  logic                 accept;
  logic [TRAVEL_W:0]    sum_w;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign best   = cand_w[TABLE_DEPTH-1];
  assign sum_w  = {1'b0, travel_r} + (TRAVEL_W+1)'(best.seek);

  assign ctl.policy = policy_r;
  assign ctl.head   = head_r;

  // Cell chain
  assign taken_w[0] = 1'b0;
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cand_t cin;
    if (i == 0) begin : g_first
      assign cin = '0;
    end else begin : g_rest
      assign cin = cand_w[i-1];
    end
    dsr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr        (wr),
      .rmv       (rmv),
      .taken_in  (taken_w[i]),
      .taken_out (taken_w[i+1]),
      .cand_in   (cin),
      .cand_out  (cand_w[i]),
      .valid_o   (valid_w[i])
    );
  end

  // Control and result formation
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    occ_nxt          = occ_r;
    head_nxt         = head_r;
    travel_nxt       = travel_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_block_nxt    = out_block_r;
    out_is_write_nxt = out_is_write_r;
    out_tag_nxt      = out_tag_r;
    out_seek_nxt     = out_seek_r;
    out_travel_nxt   = out_travel_r;
    wr.en            = 1'b0;
    wr.block         = in_request_block;
    wr.is_write      = in_request_is_write;
    wr.tag           = in_request_tag;
    wr.rank          = occ_r[RANK_W-1:0];
    rmv.en           = 1'b0;
    rmv.rank         = best.rank;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_block_nxt    = '0;
          out_is_write_nxt = 1'b0;
          out_tag_nxt      = '0;
          out_seek_nxt     = '0;
          out_travel_nxt   = travel_r;
          if (in_opcode == OP_ENQUEUE) begin
            out_valid_nxt = 1'b1;
            if (occ_r < OCC_W'(TABLE_DEPTH)) begin
              wr.en          = 1'b1;
              occ_nxt        = occ_r + 1'b1;
              out_status_nxt = ST_ACCEPTED;
            end else begin
              out_status_nxt = ST_FULL;
            end
          end else if (occ_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else begin
            state_nxt = S_SCAN;
            cnt_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RANK_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        rmv.en           = 1'b1;
        occ_nxt          = occ_r - 1'b1;
        head_nxt         = best.block;
        travel_nxt       = sum_w[TRAVEL_W] ? '1 : sum_w[TRAVEL_W-1:0];
        out_valid_nxt    = 1'b1;
        out_status_nxt   = ST_DISPATCHED;
        out_block_nxt    = best.block;
        out_is_write_nxt = best.is_write;
        out_tag_nxt      = best.tag;
        out_seek_nxt     = best.seek;
        out_travel_nxt   = sum_w[TRAVEL_W] ? '1 : sum_w[TRAVEL_W-1:0];
        state_nxt        = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      occ_r       <= '0;
      head_r      <= '0;
      travel_r    <= '0;
      policy_r    <= POL_FCFS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      travel_r    <= travel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    out_status_r   <= out_status_nxt;
    out_block_r    <= out_block_nxt;
    out_is_write_r <= out_is_write_nxt;
    out_tag_r      <= out_tag_nxt;
    out_seek_r     <= out_seek_nxt;
    out_travel_r   <= out_travel_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block         = out_block_r;
  assign out_is_write      = out_is_write_r;
  assign out_tag           = out_tag_r;
  assign out_seek_distance = out_seek_r;
  assign out_total_travel  = out_travel_r;

  // Occupancy tracks the valid map
  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == 32'(occ_r))
    else $error("occupancy does not match valid entries");

  // Occupancy never exceeds the table
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  // Retiring a scan always reports a dispatch of a valid candidate
  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH |-> best.valid ##1 (out_valid && out_status == ST_DISPATCHED))
    else $error("scan finished without a dispatch result");

  // Dispatch on an empty table answers at once
  a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_DISPATCH && occ_r == '0) |=>
      (out_valid && out_status == ST_EMPTY && !busy))
    else $error("empty dispatch not answered");

endmodule

[sim/disk_request_scheduler_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the disk request scheduler: directed cases, random traffic, sweeps.
module disk_request_scheduler_unit_test;
  import dsr_pkg::*;

  localparam int         SETTLE_CYCLES = 24;          // longer than a full dispatch
  localparam longint     TIMEOUT_NS    = 48_000_000;
  localparam int         MAX_REPORTS   = 10;
  localparam int         SEND_GAP_PCT  = 35;
  localparam int         SWEEP_PAIRS   = 10;
  localparam logic [1:0] POL_SPARE     = 2'd3;        // unused code, acts as circular scan

  // One scheduler reply, field by field
  typedef struct packed {
    logic [1:0]          status;
    logic [BLOCK_W-1:0]  block;
    logic                is_write;
    logic [TAG_W-1:0]    tag;
    logic [BLOCK_W-1:0]  seek;
    logic [TRAVEL_W-1:0] travel;
  } reply_t;

  logic                clk                 = 1'b0;
  logic                rst_n               = 1'b0;
  logic                start               = 1'b0;
  logic                busy;
  logic                in_opcode           = OP_ENQUEUE;
  logic [BLOCK_W-1:0]  in_request_block    = '0;
  logic                in_request_is_write = 1'b0;
  logic [TAG_W-1:0]    in_request_tag      = '0;
  logic                cfg_we              = 1'b0;
  logic [1:0]          cfg_wdata           = POL_FCFS;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [BLOCK_W-1:0]  out_block;
  logic                out_is_write;
  logic [TAG_W-1:0]    out_tag;
  logic [BLOCK_W-1:0]  out_seek_distance;
  logic [TRAVEL_W-1:0] out_total_travel;

  // Shadow of the request table, head and travel
  logic                tbl_valid [TABLE_DEPTH];
  logic [BLOCK_W-1:0]  tbl_block [TABLE_DEPTH];
  logic                tbl_write [TABLE_DEPTH];
  logic [TAG_W-1:0]    tbl_tag   [TABLE_DEPTH];
  int                  tbl_rank  [TABLE_DEPTH];
  int                  queued_count;
  logic [BLOCK_W-1:0]  head_pos;
  logic [TRAVEL_W-1:0] travel_acc;
  logic [1:0]          policy_now;

  reply_t              replies_due[$];
  int                  fail_count = 0;
  bit                  gaps_on    = 1'b1;

  // Block values that collide often, to force tie breaks
  logic [BLOCK_W-1:0]  tie_pool [8] = '{16'd0, 16'd100, 16'd200, 16'd300,
                                        16'd32768, 16'd32868, 16'd65435, 16'd65535};

  disk_request_scheduler_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_request_block    (in_request_block),
    .in_request_is_write (in_request_is_write),
    .in_request_tag      (in_request_tag),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_block           (out_block),
    .out_is_write        (out_is_write),
    .out_tag             (out_tag),
    .out_seek_distance   (out_seek_distance),
    .out_total_travel    (out_total_travel)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, what);
  endfunction

  function automatic logic [BLOCK_W-1:0] head_gap(logic [BLOCK_W-1:0] blk);
    return (blk >= head_pos) ? blk - head_pos : head_pos - blk;
  endfunction

  // True when entry c is preferred over entry b under the current policy
  function automatic bit outranks(int c, int b);
    bit later;
    bit c_ahead;
    bit b_ahead;
    later   = tbl_rank[c] > tbl_rank[b];
    c_ahead = tbl_block[c] >= head_pos;
    b_ahead = tbl_block[b] >= head_pos;
    if (policy_now == POL_FCFS) return tbl_rank[c] < tbl_rank[b];
    if (policy_now == POL_SSTF) begin
      if (head_gap(tbl_block[c]) != head_gap(tbl_block[b]))
        return head_gap(tbl_block[c]) < head_gap(tbl_block[b]);
      return later;
    end
    // circular scan: at or above the head first, then lowest block
    if (c_ahead != b_ahead) return c_ahead;
    if (tbl_block[c] != tbl_block[b]) return tbl_block[c] < tbl_block[b];
    return later;
  endfunction

  // Applies one request to the shadow table and returns the reply it should produce
  function automatic reply_t schedule_request(logic op, logic [BLOCK_W-1:0] blk, logic wr,
                                              logic [TAG_W-1:0] tag);
    reply_t            r;
    int                pick;
    logic [TRAVEL_W:0] sum;
    r    = '0;
    pick = -1;
    if (op == OP_ENQUEUE) begin
      r.status = ST_FULL;
      if (queued_count < TABLE_DEPTH) begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (!tbl_valid[i] && pick < 0) pick = i;
        tbl_valid[pick] = 1'b1;
        tbl_block[pick] = blk;
        tbl_write[pick] = wr;
        tbl_tag[pick]   = tag;
        tbl_rank[pick]  = queued_count;
        queued_count++;
        r.status = ST_ACCEPTED;
      end
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (tbl_valid[i] && (pick < 0 || outranks(i, pick))) pick = i;
      if (pick < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status   = ST_DISPATCHED;
        r.block    = tbl_block[pick];
        r.is_write = tbl_write[pick];
        r.tag      = tbl_tag[pick];
        r.seek     = head_gap(tbl_block[pick]);
        sum        = {1'b0, travel_acc} + (TRAVEL_W+1)'(r.seek);
        travel_acc = sum[TRAVEL_W] ? '1 : sum[TRAVEL_W-1:0];
        head_pos   = tbl_block[pick];
        tbl_valid[pick] = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tbl_valid[i] && tbl_rank[i] > tbl_rank[pick]) tbl_rank[i]--;
        queued_count--;
      end
    end
    r.travel = travel_acc;
    return r;
  endfunction

  // Random block: full range, tie-prone values, near the head, or an extreme
  function automatic logic [BLOCK_W-1:0] pick_block();
    logic [BLOCK_W-1:0] near;
    logic [BLOCK_W-1:0] off;
    off  = BLOCK_W'($urandom_range(6));
    near = head_pos + off - 16'd3;
    case ($urandom_range(4)) inside
      [0:1]:   return BLOCK_W'($urandom);
      2:       return tie_pool[3'($urandom_range(7))];
      3:       return near;
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // Sends one request, with an optional idle gap, and books its reply
  task automatic send_item(input logic op, input logic [BLOCK_W-1:0] blk, input logic wr,
                           input logic [TAG_W-1:0] tag);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(99) < SEND_GAP_PCT) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start               <= 1'b1;
    in_opcode           <= op;
    in_request_block    <= blk;
    in_request_is_write <= wr;
    in_request_tag      <= tag;
    do @(posedge clk); while (busy);
    replies_due.push_back(schedule_request(op, blk, wr, tag));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Policy changes only with the table idle
  task automatic write_policy(input logic [1:0] pol);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= pol;
    @(negedge clk);
    cfg_we    <= 1'b0;
    policy_now = pol;
  endtask

  task automatic send_dispatch();
    send_item(OP_DISPATCH, BLOCK_W'($urandom), 1'($urandom_range(1)), TAG_W'($urandom));
  endtask

  // Reply check on every strobe
  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (rst_n && out_valid) begin
      got = {out_status, out_block, out_is_write, out_tag, out_seek_distance, out_total_travel};
      if (replies_due.size() == 0) begin
        note_failure($sformatf("unexpected reply, status %0d block %0d", out_status, out_block));
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status || got.block !== want.block ||
            got.is_write !== want.is_write || got.tag !== want.tag ||
            got.seek !== want.seek || got.travel !== want.travel)
          note_failure($sformatf(
            "exp st %0d blk %0d wr %0d tag %0d seek %0d trav %0d / got %0d %0d %0d %0d %0d %0d",
            want.status, want.block, want.is_write, want.tag, want.seek, want.travel,
            got.status, got.block, got.is_write, got.tag, got.seek, got.travel));
      end
    end
  end

  // Dispatch on the empty table, under the reset policy
  task automatic test_empty_dispatch();
    send_item(OP_DISPATCH, '1, 1'b1, '1);
  endtask

  // Fill all entries, overflow once, then one oldest-first dispatch
  task automatic test_fill_and_overflow();
    logic [BLOCK_W-1:0] blocks [TABLE_DEPTH];
    blocks = '{16'd1000, 16'd65535, 16'd0, 16'd1000, 16'd1200, 16'd800, 16'd5000, 16'd5000,
               16'd300, 16'd60000, 16'd2, 16'd40000, 16'd1000, 16'd7, 16'd65534, 16'd100};
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(OP_ENQUEUE, blocks[i], i[0], 8'(i * 17));
    send_item(OP_ENQUEUE, 16'd12345, 1'b1, 8'hA5);
    send_dispatch();
  endtask

  // Nearest first: duplicate blocks and equal distances on both sides
  task automatic test_nearest_ties();
    write_policy(POL_SSTF);
    repeat (3) send_dispatch();
  endtask

  // Circular scan upward, then the spare code through the wrap to the lowest block
  task automatic test_circular_wrap();
    write_policy(POL_CSCAN);
    repeat (4) send_dispatch();
    write_policy(POL_SPARE);
    repeat (5) send_dispatch();
  endtask

  // Phases of random traffic, each under its own policy and fill pressure
  task automatic test_random_traffic();
    logic [1:0] phase_policy [6];
    int         enq_pct      [6];
    phase_policy = '{POL_SSTF, POL_CSCAN, POL_FCFS, POL_SPARE, POL_CSCAN, POL_SSTF};
    enq_pct      = '{70, 40, 55, 35, 65, 50};
    for (int p = 0; p < 6; p++) begin
      write_policy(phase_policy[p]);
      gaps_on = (p != 3);  // one phase back to back
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(99) < enq_pct[p])
          send_item(OP_ENQUEUE, pick_block(), 1'($urandom_range(1)), TAG_W'($urandom));
        else
          send_dispatch();
      end
    end
    gaps_on = 1'b1;
  endtask

  // Full-range sweeps: drain the table, then each dispatch moves the head to an end, from the second on end to end
  task automatic test_full_sweeps();
    write_policy(POL_FCFS);
    gaps_on = 1'b0;
    while (queued_count > 0) send_dispatch();
    for (int n = 0; n < SWEEP_PAIRS; n++) begin
      send_item(OP_ENQUEUE, (head_pos == '0) ? '1 : '0, 1'($urandom_range(1)),
                TAG_W'($urandom));
      send_dispatch();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_block[i] = '0;
      tbl_write[i] = 1'b0;
      tbl_tag[i]   = '0;
      tbl_rank[i]  = 0;
    end
    queued_count = 0;
    head_pos     = '0;
    travel_acc   = '0;
    policy_now   = POL_FCFS;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_dispatch();
    test_fill_and_overflow();
    test_nearest_ties();
    test_circular_wrap();
    test_random_traffic();
    test_full_sweeps();
    wait_drained();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/dsr_pkg.sv
hw/rtl/dsr_cell.sv
hw/rtl/disk_request_scheduler_unit.sv
sim/disk_request_scheduler_unit_test.sv
